[rtl/amfp_pkg.sv]
// Shared types and constants for the alert message field parser.
// Depends on nothing; used by amfp_parse, alert_message_field_parser and the testbench.
`timescale 1ns / 1ps

package amfp_pkg;

	// result kinds
	localparam logic [2:0] KIND_SEQ   = 3'd0;
	localparam logic [2:0] KIND_FLAGS = 3'd1;
	localparam logic [2:0] KIND_ERRNUM = 3'd2;
	localparam logic [2:0] KIND_SEV   = 3'd3;
	localparam logic [2:0] KIND_TEXT  = 3'd4;
	localparam logic [2:0] KIND_ARG   = 3'd5;
	localparam logic [2:0] KIND_ERROR = 3'd6;

	// error codes
	localparam logic [3:0] ERR_SEQ_DIGIT    = 4'd0;
	localparam logic [3:0] ERR_SEQ_COLON    = 4'd1;
	localparam logic [3:0] ERR_FLAG_OPEN    = 4'd2;
	localparam logic [3:0] ERR_FLAG_DIGIT   = 4'd3;
	localparam logic [3:0] ERR_FLAG_CLOSE   = 4'd4;
	localparam logic [3:0] ERR_ERRNUM_OPEN  = 4'd5;
	localparam logic [3:0] ERR_ERRNUM_DIGIT = 4'd6;
	localparam logic [3:0] ERR_ERRNUM_CLOSE = 4'd7;
	localparam logic [3:0] ERR_SEVERITY     = 4'd8;
	localparam logic [3:0] ERR_TEXT_PERIOD  = 4'd9;
	localparam logic [3:0] ERR_TEXT_OVERFLOW = 4'd10;
	localparam logic [3:0] ERR_ARG_OPEN     = 4'd11;
	localparam logic [3:0] ERR_ARG_CLOSE    = 4'd12;
	localparam logic [3:0] ERR_CODE_MAX     = ERR_ARG_CLOSE;

	// delimiter characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef struct packed {
		logic        emit;
		logic [2:0]  kind;
		logic [31:0] value;
		logic [2:0]  arg_index;
		logic [3:0]  error_code;
		logic        last;
	} result_t;

	// severity pair lookup: {match, code}
	function automatic logic [3:0] sev_lookup(input logic [7:0] a, input logic [7:0] b);
		logic [3:0] r;
		r = 4'b0000;
		if (a == "V" && b == "L") r = {1'b1, 3'd0};
		else if (a == "I" && b == "N") r = {1'b1, 3'd1};
		else if (a == "W" && b == "A") r = {1'b1, 3'd2};
		else if (a == "C" && b == "R") r = {1'b1, 3'd3};
		else if (a == "F" && b == "O") r = {1'b1, 3'd4};
		else if (a == "L" && b == "G") r = {1'b1, 3'd5};
		return r;
	endfunction

endpackage

[rtl/amfp_parse.sv]
// Parser state machine: phase, accumulator and counters, one character per step.
// Depends on amfp_pkg.
`timescale 1ns / 1ps

module amfp_parse #(
	parameter int ARG_COUNT = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [7:0]       ch,
	input  logic [7:0]       text_limit,
	output amfp_pkg::result_t res
);

	localparam logic [3:0] PH_SEQ       = 4'd0;
	localparam logic [3:0] PH_FLAG_SEEK = 4'd1;
	localparam logic [3:0] PH_FLAG      = 4'd2;
	localparam logic [3:0] PH_ERR_SEEK  = 4'd3;
	localparam logic [3:0] PH_ERR       = 4'd4;
	localparam logic [3:0] PH_SPACE     = 4'd5;
	localparam logic [3:0] PH_SEV2      = 4'd6;
	localparam logic [3:0] PH_DASH      = 4'd7;
	localparam logic [3:0] PH_SKIP      = 4'd8;
	localparam logic [3:0] PH_TEXT      = 4'd9;
	localparam logic [3:0] PH_ARG_SEEK  = 4'd10;
	localparam logic [3:0] PH_ARG       = 4'd11;
	localparam logic [3:0] PH_DISCARD   = 4'd12;

	localparam logic [3:0] ARG_LAST = 4'(ARG_COUNT);

	logic [3:0]  phase_q, phase_d;
	logic [31:0] acc_q, acc_d;
	logic [7:0]  text_cnt_q, text_cnt_d;
	logic [2:0]  arg_cnt_q, arg_cnt_d;
	logic [1:0]  skip_cnt_q, skip_cnt_d;
	logic [7:0]  sev_first_q, sev_first_d;

	logic        is_digit;
	logic        is_nul;
	logic [31:0] acc_digit;
	logic [3:0]  sev;
	logic        do_fail;
	logic [3:0]  fail_code;
	logic        do_restart;

	assign is_digit  = (ch >= amfp_pkg::CH_ZERO) && (ch <= amfp_pkg::CH_NINE);
	assign is_nul    = (ch == amfp_pkg::CH_NUL);
	// acc * 10 + digit, shifts and adds
	assign acc_digit = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0}
		+ {24'd0, ch - amfp_pkg::CH_ZERO};
	assign sev       = amfp_pkg::sev_lookup(sev_first_q, ch);

	always_comb begin
		phase_d     = phase_q;
		acc_d       = acc_q;
		text_cnt_d  = text_cnt_q;
		arg_cnt_d   = arg_cnt_q;
		skip_cnt_d  = skip_cnt_q;
		sev_first_d = sev_first_q;
		res         = '0;
		do_fail     = 1'b0;
		fail_code   = amfp_pkg::ERR_SEQ_DIGIT;
		do_restart  = 1'b0;

		unique case (phase_q)
			PH_SEQ: begin
				if (ch == amfp_pkg::CH_COLON) begin
					res.emit  = 1'b1;
					res.kind  = amfp_pkg::KIND_SEQ;
					res.value = acc_q;
					acc_d     = '0;
					phase_d   = PH_FLAG_SEEK;
				end else if (is_nul) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_SEQ_COLON;
				end else if (!is_digit) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_SEQ_DIGIT;
				end else begin
					acc_d = acc_digit;
				end
			end
			PH_FLAG_SEEK: begin
				if (ch == amfp_pkg::CH_LBRACK) begin
					acc_d = '0; phase_d = PH_FLAG;
				end else if (is_nul) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_FLAG_OPEN;
				end
			end
			PH_FLAG: begin
				if (ch == amfp_pkg::CH_RBRACK) begin
					res.emit  = 1'b1;
					res.kind  = amfp_pkg::KIND_FLAGS;
					res.value = acc_q;
					acc_d     = '0;
					phase_d   = PH_ERR_SEEK;
				end else if (is_nul) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_FLAG_CLOSE;
				end else if (!is_digit) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_FLAG_DIGIT;
				end else begin
					acc_d = acc_digit;
				end
			end
			PH_ERR_SEEK: begin
				if (ch == amfp_pkg::CH_LPAREN) begin
					acc_d = '0; phase_d = PH_ERR;
				end else if (is_nul) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_ERRNUM_OPEN;
				end
			end
			PH_ERR: begin
				if (ch == amfp_pkg::CH_RPAREN) begin
					res.emit  = 1'b1;
					res.kind  = amfp_pkg::KIND_ERRNUM;
					res.value = acc_q;
					acc_d     = '0;
					phase_d   = PH_SPACE;
				end else if (is_nul) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_ERRNUM_CLOSE;
				end else if (!is_digit) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_ERRNUM_DIGIT;
				end else begin
					acc_d = acc_digit;
				end
			end
			PH_SPACE: begin
				if (is_nul) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_SEVERITY;
				end else if (ch != amfp_pkg::CH_SPACE) begin
					sev_first_d = ch;
					phase_d     = PH_SEV2;
				end
			end
			PH_SEV2: begin
				// a zero here never matches a pair
				if (!sev[3]) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_SEVERITY;
				end else begin
					res.emit  = 1'b1;
					res.kind  = amfp_pkg::KIND_SEV;
					res.value = {29'd0, sev[2:0]};
					phase_d   = PH_DASH;
				end
			end
			PH_DASH: begin
				if (is_nul) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_TEXT_PERIOD;
				end else if (ch != amfp_pkg::CH_DASH) begin
					skip_cnt_d = 2'd1;
					phase_d    = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (is_nul) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_TEXT_PERIOD;
				end else if (skip_cnt_q >= 2'd2) begin
					skip_cnt_d = '0;
					text_cnt_d = '0;
					phase_d    = PH_TEXT;
				end else begin
					skip_cnt_d = skip_cnt_q + 2'd1;
				end
			end
			PH_TEXT: begin
				if (ch == amfp_pkg::CH_PERIOD) begin
					arg_cnt_d = '0; phase_d = PH_ARG_SEEK;
				end else if (is_nul) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_TEXT_PERIOD;
				end else if (text_cnt_q >= text_limit) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_TEXT_OVERFLOW;
				end else begin
					text_cnt_d = text_cnt_q + 8'd1;
					res.emit   = 1'b1;
					res.kind   = amfp_pkg::KIND_TEXT;
					res.value  = {24'd0, ch};
				end
			end
			PH_ARG_SEEK: begin
				if (ch == amfp_pkg::CH_LPAREN) begin
					acc_d = '0; phase_d = PH_ARG;
				end else if (is_nul) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_ARG_OPEN;
				end
			end
			PH_ARG: begin
				if (ch == amfp_pkg::CH_RPAREN) begin
					res.emit      = 1'b1;
					res.kind      = amfp_pkg::KIND_ARG;
					res.value     = acc_q;
					res.arg_index = arg_cnt_q;
					acc_d         = '0;
					if (({1'b0, arg_cnt_q} + 4'd1) >= ARG_LAST) begin
						res.last = 1'b1;
						phase_d  = PH_DISCARD;
					end else begin
						arg_cnt_d = arg_cnt_q + 3'd1;
						phase_d   = PH_ARG_SEEK;
					end
				end else if (!is_digit) begin
					do_fail = 1'b1; fail_code = amfp_pkg::ERR_ARG_CLOSE;
				end else begin
					acc_d = acc_digit;
				end
			end
			default: begin
				// discard up to the terminator
				if (is_nul) do_restart = 1'b1;
				else phase_d = PH_DISCARD;
			end
		endcase

		if (do_fail) begin
			res.emit       = 1'b1;
			res.kind       = amfp_pkg::KIND_ERROR;
			res.value      = '0;
			res.arg_index  = '0;
			res.error_code = fail_code;
			res.last       = 1'b1;
			if (is_nul) do_restart = 1'b1;
			else phase_d = PH_DISCARD;
		end

		if (do_restart) begin
			phase_d     = PH_SEQ;
			acc_d       = '0;
			text_cnt_d  = '0;
			arg_cnt_d   = '0;
			skip_cnt_d  = '0;
			sev_first_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SEQ;
			acc_q       <= '0;
			text_cnt_q  <= '0;
			arg_cnt_q   <= '0;
			skip_cnt_q  <= '0;
			sev_first_q <= '0;
		end else if (step_en) begin
			phase_q     <= phase_d;
			acc_q       <= acc_d;
			text_cnt_q  <= text_cnt_d;
			arg_cnt_q   <= arg_cnt_d;
			skip_cnt_q  <= skip_cnt_d;
			sev_first_q <= sev_first_d;
		end
	end

endmodule

[rtl/alert_message_field_parser.sv]
// Top level of the alert message field parser: input and result registers, handshakes,
// text limit register. Depends on amfp_pkg and amfp_parse.
`timescale 1ns / 1ps

// Channel   | Signals                                    | Direction
// ----------+--------------------------------------------+----------
// input     | in_valid, in_ready, ch                     | in
// result    | out_valid, out_ready, kind, value,         | out
//           | arg_index, error_code, last                |
// config    | text_limit_we, text_limit_wdata            | in
//
// One character per cycle while results are taken; a beat goes from acceptance
// through the input register, then the parse step into the result register.
// The parse step is one phase transition plus a shift-add multiply by ten.
// Reset clears parser state, valid flags and sets text limit to 255; no init sweep.
// A result waiting in the output register stalls the parse step only; the input
// register still takes one beat, so upstream sees ready until both are full.

module alert_message_field_parser #(
	parameter int ARG_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [31:0] value,
	output logic [2:0]  arg_index,
	output logic [3:0]  error_code,
	output logic        last,

	input  logic        text_limit_we,
	input  logic [7:0]  text_limit_wdata
);

	logic              valid_s1;
	logic [7:0]        ch_s1;
	logic              valid_s2;
	amfp_pkg::result_t res_s2;
	amfp_pkg::result_t res;
	logic [7:0]        text_limit_q;
	logic              advance;

	// parse step fires when a character is held and the result slot is free
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_limit_q <= 8'd255;
		end else if (text_limit_we) begin
			text_limit_q <= text_limit_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) ch_s1 <= ch;
	end

	amfp_parse #(
		.ARG_COUNT(ARG_COUNT)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.ch        (ch_s1),
		.text_limit(text_limit_q),
		.res       (res)
	);

	// result register; beats that produce nothing leave it empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.emit;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) res_s2 <= res;
	end

	assign out_valid  = valid_s2;
	assign kind       = res_s2.kind;
	assign value      = res_s2.value;
	assign arg_index  = res_s2.arg_index;
	assign error_code = res_s2.error_code;
	assign last       = res_s2.last;

	// ready drops only when both stages are full and the result is stuck
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input stalled without a full pipeline");

	// every error ends a message
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.kind == amfp_pkg::KIND_ERROR) |-> res_s2.last)
		else $error("error result without last mark");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.kind == amfp_pkg::KIND_ERROR)
			|-> (res_s2.error_code <= amfp_pkg::ERR_CODE_MAX))
		else $error("error code out of range");

	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.kind != amfp_pkg::KIND_ERROR) |-> (res_s2.error_code == 4'd0))
		else $error("error code set on a non-error result");

	a_arg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.kind == amfp_pkg::KIND_ARG)
			|-> ({1'b0, res_s2.arg_index} < 4'(ARG_COUNT)))
		else $error("argument index beyond argument count");

endmodule

[test/alert_message_field_parser_tb.sv]
// Self-checking bench for alert_message_field_parser: random alert messages fed
// through valid/ready, results checked against an in-bench parser model.
// Depends on amfp_pkg and the alert_message_field_parser RTL.
`timescale 1ns / 1ps

module alert_message_field_parser_tb;

	localparam int ARG_COUNT   = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 21;   // percent of cycles each side idles
	localparam int SETTLE      = 8;    // quiet cycles before a limit write / at the end
	localparam int MAX_REPORTS = 10;
	localparam int CALM_FROM   = 250;  // beat window with no idling on either side
	localparam int CALM_TO     = 420;
	localparam int PHASE_CHARS = 60;   // at least this many random characters per text limit setting

	// severity codes carried in value
	localparam int SEV_VL = 0;
	localparam int SEV_IN = 1;
	localparam int SEV_WA = 2;
	localparam int SEV_CR = 3;
	localparam int SEV_FO = 4;
	localparam int SEV_LG = 5;

	typedef enum logic [3:0] {
		P_SEQ, P_FLAG_SEEK, P_FLAG, P_ERR_SEEK, P_ERR, P_SPACE, P_SEV2,
		P_DASH, P_SKIP, P_TEXT, P_ARG_SEEK, P_ARG, P_DISCARD
	} parse_phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic [2:0]  arg_index;
		logic [3:0]  error_code;
		logic        last;
	} alert_field_t;

	// one queued stimulus entry: a character beat or a text limit write
	typedef struct {
		bit         is_limit;
		logic [7:0] data;
	} stim_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  ch;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  kind;
	logic [31:0] value;
	logic [2:0]  arg_index;
	logic [3:0]  error_code;
	logic        last;
	logic        text_limit_we;
	logic [7:0]  text_limit_wdata;

	alert_message_field_parser #(
		.ARG_COUNT(ARG_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.value(value),
		.arg_index(arg_index),
		.error_code(error_code),
		.last(last),
		.text_limit_we(text_limit_we),
		.text_limit_wdata(text_limit_wdata)
	);

	// parser model state
	parse_phase_t parse_at;
	logic [31:0]  acc;
	logic [7:0]   text_cnt;
	logic [2:0]   arg_cnt;
	logic [1:0]   skip_cnt;
	logic [7:0]   sev_first;
	logic [7:0]   limit_reg;

	stim_t        char_queue[$];       // pending beats and limit writes
	alert_field_t predicted_fields[$]; // results owed by the DUT, oldest first
	logic [7:0]   msg[$];              // message under construction

	int  cycle_count;
	int  chars_accepted;
	int  quiet_cycles;    // cycles since the last input beat
	int  mismatches;
	bit  in_taken;        // input beat accepted at the last rising edge

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------

	task automatic clear_message();
		parse_at  = P_SEQ;
		acc       = '0;
		text_cnt  = '0;
		arg_cnt   = '0;
		skip_cnt  = '0;
		sev_first = '0;
	endtask

	function automatic bit is_digit(logic [7:0] c);
		return c >= amfp_pkg::CH_ZERO && c <= amfp_pkg::CH_NINE;
	endfunction

	function automatic int severity_of(logic [7:0] a, logic [7:0] b);
		case ({a, b})
			{"V", "L"}: return SEV_VL;
			{"I", "N"}: return SEV_IN;
			{"W", "A"}: return SEV_WA;
			{"C", "R"}: return SEV_CR;
			{"F", "O"}: return SEV_FO;
			{"L", "G"}: return SEV_LG;
			default:    return -1;
		endcase
	endfunction

	// A zero byte raising the error starts a fresh message at once;
	// anything else drops the rest of the message.
	task automatic raise_error(input logic [7:0] c, input logic [3:0] code,
		output alert_field_t r);
		r = '0;
		r.kind = amfp_pkg::KIND_ERROR;
		r.error_code = code;
		r.last = 1'b1;
		if (c == amfp_pkg::CH_NUL)
			clear_message();
		else
			parse_at = P_DISCARD;
	endtask

	task automatic parse_char(input logic [7:0] c, output bit hit, output alert_field_t r);
		int sev;
		hit = 1'b0;
		r = '0;
		case (parse_at)
			P_SEQ: begin
				if (c == amfp_pkg::CH_COLON) begin
					hit = 1'b1;
					r.kind = amfp_pkg::KIND_SEQ;
					r.value = acc;
					acc = '0;
					parse_at = P_FLAG_SEEK;
				end else if (c == amfp_pkg::CH_NUL) begin
					hit = 1'b1;
					raise_error(c, amfp_pkg::ERR_SEQ_COLON, r);
				end else if (!is_digit(c)) begin
					hit = 1'b1;
					raise_error(c, amfp_pkg::ERR_SEQ_DIGIT, r);
				end else begin
					acc = acc * 32'd10 + 32'(c - amfp_pkg::CH_ZERO);
				end
			end
			P_FLAG_SEEK: begin
				if (c == amfp_pkg::CH_LBRACK) begin
					acc = '0;
					parse_at = P_FLAG;
				end else if (c == amfp_pkg::CH_NUL) begin
					hit = 1'b1;
					raise_error(c, amfp_pkg::ERR_FLAG_OPEN, r);
				end
			end
			P_FLAG: begin
				if (c == amfp_pkg::CH_RBRACK) begin
					hit = 1'b1;
					r.kind = amfp_pkg::KIND_FLAGS;
					r.value = acc;
					acc = '0;
					parse_at = P_ERR_SEEK;
				end else if (c == amfp_pkg::CH_NUL) begin
					hit = 1'b1;
					raise_error(c, amfp_pkg::ERR_FLAG_CLOSE, r);
				end else if (!is_digit(c)) begin
					hit = 1'b1;
					raise_error(c, amfp_pkg::ERR_FLAG_DIGIT, r);
				end else begin
					acc = acc * 32'd10 + 32'(c - amfp_pkg::CH_ZERO);
				end
			end
			P_ERR_SEEK: begin
				if (c == amfp_pkg::CH_LPAREN) begin
					acc = '0;
					parse_at = P_ERR;
				end else if (c == amfp_pkg::CH_NUL) begin
					hit = 1'b1;
					raise_error(c, amfp_pkg::ERR_ERRNUM_OPEN, r);
				end
			end
			P_ERR: begin
				if (c == amfp_pkg::CH_RPAREN) begin
					hit = 1'b1;
					r.kind = amfp_pkg::KIND_ERRNUM;
					r.value = acc;
					acc = '0;
					parse_at = P_SPACE;
				end else if (c == amfp_pkg::CH_NUL) begin
					hit = 1'b1;
					raise_error(c, amfp_pkg::ERR_ERRNUM_CLOSE, r);
				end else if (!is_digit(c)) begin
					hit = 1'b1;
					raise_error(c, amfp_pkg::ERR_ERRNUM_DIGIT, r);
				end else begin
					acc = acc * 32'd10 + 32'(c - amfp_pkg::CH_ZERO);
				end
			end
			P_SPACE: begin
				if (c == amfp_pkg::CH_NUL) begin
					hit = 1'b1;
					raise_error(c, amfp_pkg::ERR_SEVERITY, r);
				end else if (c != amfp_pkg::CH_SPACE) begin
					sev_first = c;
					parse_at = P_SEV2;
				end
			end
			P_SEV2: begin
				// pair is judged on its second character
				sev = severity_of(sev_first, c);
				hit = 1'b1;
				if (sev < 0) begin
					raise_error(c, amfp_pkg::ERR_SEVERITY, r);
				end else begin
					r.kind = amfp_pkg::KIND_SEV;
					r.value = 32'(sev);
					parse_at = P_DASH;
				end
			end
			P_DASH: begin
				if (c == amfp_pkg::CH_NUL) begin
					hit = 1'b1;
					raise_error(c, amfp_pkg::ERR_TEXT_PERIOD, r);
				end else if (c != amfp_pkg::CH_DASH) begin
					skip_cnt = 2'd1;
					parse_at = P_SKIP;
				end
			end
			P_SKIP: begin
				if (c == amfp_pkg::CH_NUL) begin
					hit = 1'b1;
					raise_error(c, amfp_pkg::ERR_TEXT_PERIOD, r);
				end else if (skip_cnt >= 2'd2) begin
					skip_cnt = '0;
					text_cnt = '0;
					parse_at = P_TEXT;
				end else begin
					skip_cnt = skip_cnt + 2'd1;
				end
			end
			P_TEXT: begin
				if (c == amfp_pkg::CH_PERIOD) begin
					arg_cnt = '0;
					parse_at = P_ARG_SEEK;
				end else if (c == amfp_pkg::CH_NUL) begin
					hit = 1'b1;
					raise_error(c, amfp_pkg::ERR_TEXT_PERIOD, r);
				end else if (text_cnt >= limit_reg) begin
					hit = 1'b1;
					raise_error(c, amfp_pkg::ERR_TEXT_OVERFLOW, r);
				end else begin
					text_cnt = text_cnt + 8'd1;
					hit = 1'b1;
					r.kind = amfp_pkg::KIND_TEXT;
					r.value = 32'(c);
				end
			end
			P_ARG_SEEK: begin
				if (c == amfp_pkg::CH_LPAREN) begin
					acc = '0;
					parse_at = P_ARG;
				end else if (c == amfp_pkg::CH_NUL) begin
					hit = 1'b1;
					raise_error(c, amfp_pkg::ERR_ARG_OPEN, r);
				end
			end
			P_ARG: begin
				hit = 1'b1;
				if (c == amfp_pkg::CH_RPAREN) begin
					r.kind = amfp_pkg::KIND_ARG;
					r.value = acc;
					r.arg_index = arg_cnt;
					acc = '0;
					if (int'(arg_cnt) + 1 >= ARG_COUNT) begin
						r.last = 1'b1;
						parse_at = P_DISCARD;
					end else begin
						arg_cnt = arg_cnt + 3'd1;
						parse_at = P_ARG_SEEK;
					end
				end else if (!is_digit(c)) begin
					raise_error(c, amfp_pkg::ERR_ARG_CLOSE, r);
				end else begin
					hit = 1'b0;
					acc = acc * 32'd10 + 32'(c - amfp_pkg::CH_ZERO);
				end
			end
			default: begin
				// silent drop up to the terminator
				if (c == amfp_pkg::CH_NUL)
					clear_message();
				else
					parse_at = P_DISCARD;
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Message generation
	// ------------------------------------------------------------------

	function automatic logic [7:0] any_byte_except(logic [7:0] avoid);
		logic [7:0] b;
		do
			b = 8'($urandom_range(255, 1));
		while (b == avoid);
		return b;
	endfunction

	// mostly short numbers, now and then long enough to wrap 32 bits
	function automatic int digit_len();
		return ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(3);
	endfunction

	task automatic put_digits(input int n);
		repeat (n) msg.push_back(amfp_pkg::CH_ZERO + 8'($urandom_range(9)));
	endtask

	// filler the seek phases and the discard phase skip over
	task automatic put_junk(input logic [7:0] avoid);
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(2, 1)) msg.push_back(any_byte_except(avoid));
	endtask

	task automatic build_alert(input int lim);
		string pairs;
		int    k;
		int    tlen;
		pairs = "VLINWACRFOLG";
		put_digits(digit_len());
		msg.push_back(amfp_pkg::CH_COLON);
		put_junk(amfp_pkg::CH_LBRACK);
		msg.push_back(amfp_pkg::CH_LBRACK);
		put_digits(digit_len());
		msg.push_back(amfp_pkg::CH_RBRACK);
		put_junk(amfp_pkg::CH_LPAREN);
		msg.push_back(amfp_pkg::CH_LPAREN);
		put_digits(digit_len());
		msg.push_back(amfp_pkg::CH_RPAREN);
		repeat ($urandom_range(2)) msg.push_back(amfp_pkg::CH_SPACE);
		k = $urandom_range(5);
		msg.push_back(8'(pairs[2 * k]));
		msg.push_back(8'(pairs[2 * k + 1]));
		repeat ($urandom_range(3)) msg.push_back(amfp_pkg::CH_DASH);
		msg.push_back(any_byte_except(amfp_pkg::CH_DASH));
		msg.push_back(any_byte_except(amfp_pkg::CH_NUL));
		msg.push_back(any_byte_except(amfp_pkg::CH_NUL));
		// small limits get text right at and one past the limit
		if (lim <= 20 && $urandom_range(99) < 30)
			tlen = lim + $urandom_range(1);
		else
			tlen = $urandom_range(lim < 5 ? lim : 5);
		repeat (tlen) msg.push_back(any_byte_except(amfp_pkg::CH_PERIOD));
		msg.push_back(amfp_pkg::CH_PERIOD);
		repeat (ARG_COUNT) begin
			put_junk(amfp_pkg::CH_LPAREN);
			msg.push_back(amfp_pkg::CH_LPAREN);
			put_digits(digit_len());
			msg.push_back(amfp_pkg::CH_RPAREN);
		end
		put_junk(amfp_pkg::CH_NUL);
		msg.push_back(amfp_pkg::CH_NUL);
	endtask

	task automatic add_chars();
		foreach (msg[i]) char_queue.push_back('{1'b0, msg[i]});
		msg.delete();
	endtask

	// ------------------------------------------------------------------
	// Clock, reset, stimulus plan, end of run
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int unsigned limits[6];
		int          budget;
		int          pick;
		int          k;

		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = '0;
		out_ready = 1'b0;
		text_limit_we = 1'b0;
		text_limit_wdata = '0;
		cycle_count = 0;
		chars_accepted = 0;
		quiet_cycles = 0;
		mismatches = 0;
		in_taken = 1'b0;
		limit_reg = 8'd255;
		clear_message();

		// opening checks: bare terminator, bad sequence digit, missing '[',
		// terminator inside flags, bad flag digit, bad errnum digit
		msg = '{amfp_pkg::CH_NUL,
			"Q", amfp_pkg::CH_NUL,
			"9", amfp_pkg::CH_COLON, amfp_pkg::CH_NUL,
			"7", amfp_pkg::CH_COLON, amfp_pkg::CH_LBRACK, amfp_pkg::CH_NUL,
			"1", amfp_pkg::CH_COLON, amfp_pkg::CH_LBRACK, "x", amfp_pkg::CH_NUL,
			"2", amfp_pkg::CH_COLON, amfp_pkg::CH_LBRACK, amfp_pkg::CH_RBRACK,
			amfp_pkg::CH_LPAREN, "y", amfp_pkg::CH_NUL};
		add_chars();

		// one phase per text limit setting, extremes included
		limits = '{0, 255, 1, 0, 2, 255};
		limits[3] = $urandom_range(254, 3);
		foreach (limits[i]) begin
			char_queue.push_back('{1'b1, 8'(limits[i])});
			budget = char_queue.size() + PHASE_CHARS;
			while (char_queue.size() < budget) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					build_alert(limits[i]);
				end else if (pick < 90) begin
					// broken message: cut short or one byte clobbered
					build_alert(limits[i]);
					k = $urandom_range(msg.size() - 2);
					if ($urandom_range(1)) begin
						while (msg.size() > k + 1) void'(msg.pop_back());
						msg.push_back(amfp_pkg::CH_NUL);
					end else begin
						msg[k] = 8'($urandom_range(255));
					end
				end else begin
					// line noise, zeros frequent
					repeat ($urandom_range(6, 1))
						msg.push_back(($urandom_range(9) < 3) ?
							amfp_pkg::CH_NUL : 8'($urandom_range(255)));
					msg.push_back(amfp_pkg::CH_NUL);
				end
				add_chars();
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (char_queue.size() != 0 || in_valid) @(posedge clk);
		while (predicted_fields.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: updates on the falling edge, one assignment per signal
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		logic       nv;
		logic [7:0] nc;
		logic       nwe;
		logic [7:0] nwd;
		bit         calm;
		if (arst_n) begin
			calm = chars_accepted >= CALM_FROM && chars_accepted < CALM_TO;
			nv = in_valid;
			nc = ch;
			nwe = 1'b0;
			nwd = text_limit_wdata;
			// a beat still waiting for ready keeps valid and payload
			if (!in_valid || in_taken) begin
				nv = 1'b0;
				if (char_queue.size() != 0) begin
					if (char_queue[0].is_limit) begin
						// limit writes only once the pipe has drained
						if (predicted_fields.size() == 0 && quiet_cycles >= SETTLE) begin
							nwe = 1'b1;
							nwd = char_queue[0].data;
							void'(char_queue.pop_front());
						end
					end else if (calm || $urandom_range(99) >= IDLE_PCT) begin
						nv = 1'b1;
						nc = char_queue[0].data;
						void'(char_queue.pop_front());
					end
				end
			end
			in_valid <= nv;
			ch <= nc;
			text_limit_we <= nwe;
			text_limit_wdata <= nwd;
			out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: samples on the rising edge, predicts and checks
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		alert_field_t got;
		alert_field_t want;
		bit           hit;
		cycle_count = cycle_count + 1;
		in_taken = 1'b0;
		if (arst_n) begin
			if (text_limit_we)
				limit_reg = text_limit_wdata;

			if (out_valid && out_ready) begin
				got = '{kind, value, arg_index, error_code, last};
				if (predicted_fields.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected kind=%0d value=%0h idx=%0d err=%0d last=%0b",
							$realtime, got.kind, got.value, got.arg_index,
							got.error_code, got.last);
				end else begin
					want = predicted_fields.pop_front();
					if (got !== want) begin
						mismatches = mismatches + 1;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t: mismatch exp kind=%0d value=%0h idx=%0d err=%0d last=%0b",
								$realtime, want.kind, want.value, want.arg_index,
								want.error_code, want.last);
							$display("%0t:          got kind=%0d value=%0h idx=%0d err=%0d last=%0b",
								$realtime, got.kind, got.value, got.arg_index,
								got.error_code, got.last);
						end
					end
				end
			end

			if (in_valid && in_ready) begin
				in_taken = 1'b1;
				chars_accepted = chars_accepted + 1;
				quiet_cycles = 0;
				parse_char(ch, hit, want);
				if (hit)
					predicted_fields.push_back(want);
			end else begin
				quiet_cycles = quiet_cycles + 1;
			end
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
